### src/vcge_pkg.sv
// ----------------------------------------------------------------------------
// vcge_pkg
// Types, register codes and arithmetic helpers for the voxel column ground
// extractor.
// ----------------------------------------------------------------------------
package vcge_pkg;

	localparam int HEIGHT_BITS   = 16;
	localparam int CFG_DATA_BITS = 15;
	localparam int CFG_IDX_BITS  = 2;
	localparam int DIFF_BITS     =
		((HEIGHT_BITS > CFG_DATA_BITS) ? HEIGHT_BITS : CFG_DATA_BITS) + 2;

	localparam logic [CFG_DATA_BITS-1:0] CLEARANCE_RESET = CFG_DATA_BITS'(1000);
	localparam logic [CFG_DATA_BITS-1:0] THRESHOLD_RESET = CFG_DATA_BITS'(300);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SIMPLE_MODE        = 2'd0,
		REG_CLEARANCE_HEIGHT   = 2'd1,
		REG_OBSTACLE_THRESHOLD = 2'd2
	} reg_index_t;

	typedef logic signed [HEIGHT_BITS-1:0] height_t;

	typedef struct packed {
		height_t voxel_height;
		logic    voxel_valid;
		logic    column_last;
		height_t robot_z;
	} voxel_in_t;

	typedef struct packed {
		height_t ground_height;
		logic    ground_valid;
		logic    obstacle;
	} ground_out_t;

	typedef struct packed {
		logic                     simple_mode;
		logic [CFG_DATA_BITS-1:0] clearance_height;
		logic [CFG_DATA_BITS-1:0] obstacle_threshold;
	} cfg_t;

	function automatic logic signed [DIFF_BITS-1:0] sext_d(input height_t v);
		return {{(DIFF_BITS-HEIGHT_BITS){v[HEIGHT_BITS-1]}}, v};
	endfunction

	function automatic logic signed [DIFF_BITS-1:0] zext_d(
		input logic [CFG_DATA_BITS-1:0] v
	);
		return {{(DIFF_BITS-CFG_DATA_BITS){1'b0}}, v};
	endfunction

	function automatic logic [HEIGHT_BITS:0] abs_diff(input height_t a, input height_t b);
		logic signed [DIFF_BITS-1:0] d;
		logic signed [DIFF_BITS-1:0] m;
		d = sext_d(a) - sext_d(b);
		m = d[DIFF_BITS-1] ? -d : d;
		return m[HEIGHT_BITS:0];
	endfunction

endpackage

### src/vcge_cfg.sv
// ----------------------------------------------------------------------------
// vcge_cfg
// Configuration register file: mode select, clearance height and obstacle
// threshold.
// ----------------------------------------------------------------------------
module vcge_cfg
	import vcge_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output cfg_t                     cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.simple_mode        <= 1'b0;
			cfg_q.clearance_height   <= CLEARANCE_RESET;
			cfg_q.obstacle_threshold <= THRESHOLD_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SIMPLE_MODE:        cfg_q.simple_mode        <= cfg_data[0];
				REG_CLEARANCE_HEIGHT:   cfg_q.clearance_height   <= cfg_data;
				REG_OBSTACLE_THRESHOLD: cfg_q.obstacle_threshold <= cfg_data;
				default:                cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/vcge_column.sv
// ----------------------------------------------------------------------------
// vcge_column
// Per-column state and the single-pass step logic: gap candidate search,
// min/max tracking and result selection.
// ----------------------------------------------------------------------------
module vcge_column
	import vcge_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  voxel_in_t   item,
	input  logic        step,
	output ground_out_t result
);

	height_t prev_q;
	logic    have_prev_q;
	height_t best_q;
	logic    have_best_q;
	height_t max_q;
	height_t min_q;

	height_t          h;
	height_t          z;
	logic             gap_hit;
	logic [HEIGHT_BITS:0] dist_prev;
	logic [HEIGHT_BITS:0] dist_best;
	logic [HEIGHT_BITS:0] dist_best1;
	logic [HEIGHT_BITS:0] dist_top;
	logic             take1;
	logic             take2;
	height_t          best1;
	logic             have_best1;
	height_t          best2;
	height_t          prev_n;
	logic             have_prev_n;
	height_t          max_n;
	height_t          min_n;

	always_comb begin
		h = item.voxel_height;
		z = item.robot_z;

		gap_hit = item.voxel_valid && have_prev_q &&
			((sext_d(h) - sext_d(prev_q)) > zext_d(cfg.clearance_height));
		dist_prev  = abs_diff(prev_q, z);
		dist_best  = abs_diff(best_q, z);
		take1      = gap_hit && (!have_best_q || (dist_prev < dist_best));
		best1      = take1 ? prev_q : best_q;
		have_best1 = have_best_q || take1;
		dist_best1 = take1 ? dist_prev : dist_best;

		prev_n      = item.voxel_valid ? h : prev_q;
		have_prev_n = have_prev_q || item.voxel_valid;
		max_n       = max_q;
		min_n       = min_q;
		if (item.voxel_valid) begin
			if (!have_prev_q) begin
				max_n = h;
				min_n = h;
			end else begin
				if (h > max_q) max_n = h;
				if (h < min_q) min_n = h;
			end
		end

		dist_top = abs_diff(prev_n, z);
		take2    = have_prev_n && (!have_best1 || (dist_top < dist_best1));
		best2    = take2 ? prev_n : best1;

		result = '0;
		if (have_prev_n) begin
			result.ground_valid = 1'b1;
			if (cfg.simple_mode) begin
				result.ground_height = min_n;
				result.obstacle =
					(sext_d(max_n) - sext_d(z)) > zext_d(cfg.obstacle_threshold);
			end else begin
				result.ground_height = best2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			best_q      <= '0;
			have_best_q <= 1'b0;
			max_q       <= '0;
			min_q       <= '0;
		end else if (step) begin
			if (item.column_last) begin
				prev_q      <= '0;
				have_prev_q <= 1'b0;
				best_q      <= '0;
				have_best_q <= 1'b0;
				max_q       <= '0;
				min_q       <= '0;
			end else begin
				prev_q      <= prev_n;
				have_prev_q <= have_prev_n;
				best_q      <= best1;
				have_best_q <= have_best1;
				max_q       <= max_n;
				min_q       <= min_n;
			end
		end
	end

endmodule

### src/voxel_column_ground_extractor.sv
// ----------------------------------------------------------------------------
// voxel_column_ground_extractor
// Streams voxel heights of one map column and emits one ground result per
// column, by nearest gap candidate or by min/max threshold.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  vox       vox_valid/vox_ready   vox (voxel_in_t)
//  gnd       gnd_valid/gnd_ready   gnd (ground_out_t)
//  cfg       cfg_valid/cfg_ready   cfg_index, cfg_data
//
//  one item per cycle; an item goes from the input register through the step
//  logic, and a column_last item goes on into the result register
//  gnd_valid is set by the same edge that loads the result register
//  reset clears column state and loads register defaults, no clearing pass
//  a column_last item waits in the input register only while the result
//  register is full and gnd_ready is low; other items never stall
// ----------------------------------------------------------------------------
module voxel_column_ground_extractor
	import vcge_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     vox_valid,
	output logic                     vox_ready,
	input  voxel_in_t                vox,
	output logic                     gnd_valid,
	input  logic                     gnd_ready,
	output ground_out_t              gnd,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	cfg_t        cfg;
	voxel_in_t   vox_s1;
	logic        valid_s1;
	ground_out_t gnd_q;
	logic        gnd_valid_q;
	ground_out_t result;
	logic        out_free;
	logic        adv_s1;

	assign cfg_ready = 1'b1;
	assign out_free  = !gnd_valid_q || gnd_ready;
	assign adv_s1    = valid_s1 && (!vox_s1.column_last || out_free);
	assign vox_ready = !valid_s1 || adv_s1;

	vcge_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	vcge_column u_column (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (vox_s1),
		.step   (adv_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (vox_ready) begin
			valid_s1 <= vox_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (vox_valid && vox_ready) begin
			vox_s1 <= vox;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gnd_valid_q <= 1'b0;
		end else if (out_free) begin
			gnd_valid_q <= adv_s1 && vox_s1.column_last;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv_s1 && vox_s1.column_last) begin
			gnd_q <= result;
		end
	end

	assign gnd_valid = gnd_valid_q;
	assign gnd       = gnd_q;

endmodule
